>>> rtl/direct_mapped_writeback_cache_assert.svh
// assertion macros used by the cache top level
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH

// same-cycle implication, held off during reset
`define DMWB_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DMWB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dmwb_pkg.sv
// shared types and constants of the direct-mapped write-back cache
package dmwb_pkg;

    localparam int ADDR_W      = 16;
    localparam int OFFSET_W    = 3;
    localparam int LINE_NO_W   = ADDR_W - OFFSET_W;
    localparam int BYTE_W      = 8;
    localparam int LINE_BYTES  = 8;
    localparam int LINE_DATA_W = BYTE_W * LINE_BYTES;
    localparam int KIND_W      = 2;

    // access kinds; any other code allocates like KIND_ALLOC
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] write_byte;
    } req_t;

    typedef struct packed {
        logic [LINE_DATA_W-1:0] line_data;
        logic                   hit;
        logic                   was_dirty;
    } rsp_t;

endpackage

>>> rtl/dmwb_ram.sv
// generic simple dual-port ram with registered read
module dmwb_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dmwb_cmod.sv
// two-stage remainder by a constant divisor through a reciprocal multiply
module dmwb_cmod #(
    parameter int IN_W    = 13,
    parameter int DIVISOR = 64,
    parameter int REM_W   = $clog2(DIVISOR)
) (
    input  logic              aclk,
    input  logic [IN_W-1:0]   num,
    output logic [REM_W-1:0]  rem
);

    localparam int SHIFT   = IN_W + $clog2(DIVISOR);
    localparam int RECIP_W = IN_W + 2;
    localparam int PROD_W  = IN_W + RECIP_W;
    localparam longint unsigned RECIP_FULL = ((64'd1 << SHIFT) / DIVISOR) + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int CW = ((IN_W > REM_W) ? IN_W : REM_W) + 1;

    logic [PROD_W-1:0] prod_reg;
    logic [IN_W-1:0]   num_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [IN_W-1:0]   quo;
    logic [IN_W-1:0]   back;
    logic [CW-1:0]     diff;
    logic [CW-1:0]     fixed;

    // stage one: estimate of the quotient
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(num) * PROD_W'(RECIP);
        num_reg  <= num;
        rem_reg  <= rem_next;
    end

    // stage two: remainder with one correction step
    always_comb begin
        quo      = IN_W'(prod_reg >> SHIFT);
        back     = IN_W'(quo * IN_W'(DIVISOR));
        diff     = CW'(num_reg) - CW'(back);
        fixed    = (diff >= CW'(DIVISOR)) ? (diff - CW'(DIVISOR)) : diff;
        rem_next = REM_W'(fixed);
    end

    assign rem = rem_reg;

endmodule

>>> rtl/direct_mapped_writeback_cache.sv
// top level of the direct-mapped write-back cache with its backing memory
//
//  channel   direction  handshake           beat payload
//  s_        in         s_valid / s_ready   dmwb_pkg::req_t  (kind, address, write_byte)
//  m_        out        m_valid / m_ready   dmwb_pkg::rsp_t  (line_data, hit, was_dirty)
//
//  one access at a time: a hit goes from accept through lookup to update, a clean miss adds the fill,
//  a dirty miss adds victim write-back, then fill, on the single backing write/read port
//  index and memory line come from registered constant-remainder units
//  after reset a clearing pass over every cache and memory line runs, s_ready low
//  a read waits in its update state only while the previous result beat is still unaccepted

`include "direct_mapped_writeback_cache_assert.svh"

module direct_mapped_writeback_cache #(
    parameter int CACHE_LINES  = 64,
    parameter int MEMORY_LINES = 8192
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dmwb_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dmwb_pkg::rsp_t  m_data
);

    localparam int LINE_W  = dmwb_pkg::LINE_NO_W;
    localparam int DATA_W  = dmwb_pkg::LINE_DATA_W;
    localparam int BYTE_W  = dmwb_pkg::BYTE_W;
    localparam int OFF_W   = dmwb_pkg::OFFSET_W;
    localparam int ADDR_W  = dmwb_pkg::ADDR_W;
    localparam int LANES   = dmwb_pkg::LINE_BYTES;
    localparam int CIDX_W  = $clog2(CACHE_LINES);
    localparam int MADDR_W = $clog2(MEMORY_LINES);
    localparam int SWEEP   = (CACHE_LINES > MEMORY_LINES) ? CACHE_LINES : MEMORY_LINES;
    localparam int CLR_W   = $clog2(SWEEP) + 1;

    // the entry keeps the full line number; equal index makes it equal to tag compare
    typedef struct packed {
        logic              dirty;
        logic [LINE_W-1:0] line_no;
        logic [DATA_W-1:0] data;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [11:0] {
        ST_CLEAR      = 12'b0000_0000_0001,
        ST_IDLE       = 12'b0000_0000_0010,
        ST_DIV_A      = 12'b0000_0000_0100,
        ST_DIV_B      = 12'b0000_0000_1000,
        ST_LOOKUP_RD  = 12'b0000_0001_0000,
        ST_COMPARE    = 12'b0000_0010_0000,
        ST_VIC_A      = 12'b0000_0100_0000,
        ST_VIC_B      = 12'b0000_1000_0000,
        ST_WRITE_BACK = 12'b0001_0000_0000,
        ST_FILL_RD    = 12'b0010_0000_0000,
        ST_FILL_DATA  = 12'b0100_0000_0000,
        ST_UPDATE     = 12'b1000_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    dmwb_pkg::req_t  req_reg, req_next;
    entry_t          entry_reg, entry_next;
    logic            hit_reg, hit_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    dmwb_pkg::rsp_t  out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic [LINE_W-1:0]  line_no;
    logic [OFF_W-1:0]   offset;
    logic [CIDX_W-1:0]  idx_rem;
    logic [MADDR_W-1:0] fill_rem;
    logic [MADDR_W-1:0] vic_rem;

    logic               cache_we;
    logic [CIDX_W-1:0]  cache_waddr;
    entry_t             cache_wdata;
    logic [ENTRY_W-1:0] cache_rdata;
    entry_t             cache_rd;

    logic               mem_we;
    logic [MADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [DATA_W-1:0]  mem_rdata;

    logic [DATA_W-1:0]  merged;
    entry_t             new_entry;
    logic               is_write;

    // address split of the held request
    assign line_no  = req_reg.address[ADDR_W-1:OFF_W];
    assign offset   = req_reg.address[OFF_W-1:0];
    assign cache_rd = entry_t'(cache_rdata);
    assign is_write = (req_reg.kind == dmwb_pkg::KIND_WRITE);

    // cache index of the request
    dmwb_cmod #(
        .IN_W    (LINE_W),
        .DIVISOR (CACHE_LINES),
        .REM_W   (CIDX_W)
    ) u_idx_mod (
        .aclk (aclk),
        .num  (line_no),
        .rem  (idx_rem)
    );

    // backing line of the fill
    dmwb_cmod #(
        .IN_W    (LINE_W),
        .DIVISOR (MEMORY_LINES),
        .REM_W   (MADDR_W)
    ) u_fill_mod (
        .aclk (aclk),
        .num  (line_no),
        .rem  (fill_rem)
    );

    // backing line of the victim
    dmwb_cmod #(
        .IN_W    (LINE_W),
        .DIVISOR (MEMORY_LINES),
        .REM_W   (MADDR_W)
    ) u_vic_mod (
        .aclk (aclk),
        .num  (entry_reg.line_no),
        .rem  (vic_rem)
    );

    // dirty flag, line number and data of each cache line in one word
    dmwb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_LINES)
    ) u_cache_ram (
        .aclk    (aclk),
        .wr_en   (cache_we),
        .wr_addr (cache_waddr),
        .wr_data (cache_wdata),
        .rd_addr (idx_rem),
        .rd_data (cache_rdata)
    );

    // backing memory, one line per word
    dmwb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_LINES)
    ) u_backing_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (fill_rem),
        .rd_data (mem_rdata)
    );

    // byte merge into the line held in entry_reg (already refilled on a miss)
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            merged[k*BYTE_W +: BYTE_W] = (is_write && offset == OFF_W'(k))
                                         ? req_reg.write_byte
                                         : entry_reg.data[k*BYTE_W +: BYTE_W];
        end
        new_entry.data    = merged;
        new_entry.line_no = line_no;
        new_entry.dirty   = is_write || (hit_reg && entry_reg.dirty);
    end

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        entry_next     = entry_reg;
        hit_next       = hit_reg;
        clr_next       = clr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        cache_we    = 1'b0;
        cache_waddr = idx_rem;
        cache_wdata = new_entry;
        mem_we      = 1'b0;
        mem_waddr   = vic_rem;
        mem_wdata   = entry_reg.data;

        unique case (state_reg)
            ST_CLEAR: begin
                // cache lines start with tag zero, i.e. line number equal to index
                cache_we            = (clr_reg < CLR_W'(CACHE_LINES));
                cache_waddr         = clr_reg[CIDX_W-1:0];
                cache_wdata.dirty   = 1'b0;
                cache_wdata.line_no = LINE_W'(clr_reg);
                cache_wdata.data    = '0;
                mem_we              = (clr_reg < CLR_W'(MEMORY_LINES));
                mem_waddr           = clr_reg[MADDR_W-1:0];
                mem_wdata           = '0;
                clr_next            = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(SWEEP - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = ST_DIV_A;
                end
            end
            ST_DIV_A: begin
                state_next = ST_DIV_B;
            end
            ST_DIV_B: begin
                state_next = ST_LOOKUP_RD;
            end
            ST_LOOKUP_RD: begin
                // index now stable at the cache read port
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                entry_next = cache_rd;
                hit_next   = (cache_rd.line_no == line_no);
                if (cache_rd.line_no == line_no) begin
                    state_next = ST_UPDATE;
                end else if (cache_rd.dirty) begin
                    state_next = ST_VIC_A;
                end else begin
                    // fill word was read alongside the lookup
                    state_next = ST_FILL_DATA;
                end
            end
            ST_VIC_A: begin
                state_next = ST_VIC_B;
            end
            ST_VIC_B: begin
                state_next = ST_WRITE_BACK;
            end
            ST_WRITE_BACK: begin
                mem_we     = 1'b1;
                state_next = ST_FILL_RD;
            end
            ST_FILL_RD: begin
                // re-read after the write-back so an aliasing victim is seen
                state_next = ST_FILL_DATA;
            end
            ST_FILL_DATA: begin
                entry_next.data = mem_rdata;
                state_next      = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (req_reg.kind == dmwb_pkg::KIND_READ) begin
                    if (!out_valid_reg || m_ready) begin
                        cache_we           = 1'b1;
                        out_next.line_data = merged;
                        out_next.hit       = hit_reg;
                        out_next.was_dirty = entry_reg.dirty;
                        out_valid_next     = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end else begin
                    cache_we   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `DMWB_ASSERT_IMPLIES(a_wb_dirty_miss, aclk, aresetn, state_reg == ST_WRITE_BACK, entry_reg.dirty && !hit_reg, "write-back of a clean or hit line")
    `DMWB_ASSERT_IMPLIES(a_fill_on_miss, aclk, aresetn, state_reg == ST_FILL_DATA, !hit_reg, "line fill on a hit")
    `DMWB_ASSERT_IMPLIES(a_one_store_update, aclk, aresetn, mem_we && state_reg != ST_CLEAR, !cache_we, "cache and backing updated together")
    `DMWB_ASSERT_NEXT(a_read_gives_beat, aclk, aresetn, state_reg == ST_UPDATE && req_reg.kind == dmwb_pkg::KIND_READ && (!out_valid_reg || m_ready), m_valid && s_ready, "read finished without a result beat")

endmodule
